### rtl/x86_segment_check_page_walk_defines.svh
// assertion macros for the segment check and page walk block
// used by the checker module only
`ifndef X86_SEGMENT_CHECK_PAGE_WALK_DEFINES_SVH
`define X86_SEGMENT_CHECK_PAGE_WALK_DEFINES_SVH
// assertion that an implication holds under clock and reset
`define XSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion that holds also during reset
`define XSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/xsc_pkg.sv
// package for the segment check and page walk block
// types and codes shared by the rtl files other than the interfaces
`timescale 1ns / 1ps
package xsc_pkg;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] RK_READ  = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_FAULT = 2'd2;

  localparam logic [1:0] FC_GP = 2'd0;
  localparam logic [1:0] FC_SS = 2'd1;
  localparam logic [1:0] FC_PF = 2'd2;

  localparam logic [1:0] AK_READ  = 2'd0;
  localparam logic [1:0] AK_WRITE = 2'd1;
  localparam logic [1:0] AK_EXEC  = 2'd2;

  localparam logic [0:0] CMD_REQ  = 1'b0;
  localparam logic [0:0] CMD_RESP = 1'b1;

  localparam logic [0:0] REG_PAGING  = 1'b0;
  localparam logic [0:0] REG_DIRBASE = 1'b1;

  typedef enum logic [1:0] {PH_IDLE, PH_DIR, PH_TBL} walk_phase_t;

  // classified item passed from front to back
  typedef struct packed {
    logic        is_resp;
    logic        seg_fault;
    logic [1:0]  fcode;
    logic        paging;
    logic [1:0]  kind;
    logic [1:0]  cpl;
    logic [31:0] linear;
    logic [31:0] data;
  } xsc_cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] mem_address;
    logic [31:0] physical_address;
    logic [1:0]  fault_code;
    logic [2:0]  pf_error_bits;
    logic [31:0] fault_linear_address;
  } xsc_res_t;
endpackage

### rtl/xsc_if.sv
// valid/ready channel interfaces for the block
// depends on nothing
`timescale 1ns / 1ps
interface xsc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  access_kind;
  logic [31:0] offset;
  logic [31:0] seg_base;
  logic [19:0] seg_limit_raw;
  logic [15:0] descriptor_flags;
  logic [1:0]  selector_rpl;
  logic        is_stack_segment;
  logic [1:0]  current_privilege;
  logic [31:0] read_data;
  modport source (output valid, command, access_kind, offset, seg_base, seg_limit_raw,
                  descriptor_flags, selector_rpl, is_stack_segment, current_privilege,
                  read_data, input ready);
  modport sink (input valid, command, access_kind, offset, seg_base, seg_limit_raw,
                descriptor_flags, selector_rpl, is_stack_segment, current_privilege,
                read_data, output ready);
endinterface

interface xsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] mem_address;
  logic [31:0] physical_address;
  logic [1:0]  fault_code;
  logic [2:0]  pf_error_bits;
  logic [31:0] fault_linear_address;
  modport source (output valid, result_kind, mem_address, physical_address, fault_code,
                  pf_error_bits, fault_linear_address, input ready);
  modport sink (input valid, result_kind, mem_address, physical_address, fault_code,
                pf_error_bits, fault_linear_address, output ready);
endinterface

interface xsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/x86_segment_check_page_walk.sv
// path: a request passes the front stage register, the queue and the result register in turn
// throughput: one item per cycle while out_ch.ready holds; front stage, 2-entry queue and result register decouple
// each walk needs one or two memory responses fed back as response items
// reset: synchronous active-low rst_n clears walk state, queue and config registers
// top level, depends on xsc_pkg, xsc_if, xsc_front, xsc_queue, xsc_back
`timescale 1ns / 1ps
module x86_segment_check_page_walk #(
  parameter int unsigned QUEUE_DEPTH = xsc_pkg::QueueDepth
) (
  input logic clk,
  input logic rst_n,
  xsc_in_if.sink   in_ch,
  xsc_out_if.source out_ch,
  xsc_cfg_if.sink  cfg_ch
);
  logic        paging_r;
  logic [19:0] dir_frame_r;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  xsc_pkg::xsc_cmd_t fq_cmd, bq_cmd;
  xsc_pkg::xsc_res_t res;

  // config registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_r <= 1'b0;
      dir_frame_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        xsc_pkg::REG_PAGING:  paging_r <= cfg_ch.data[0];
        xsc_pkg::REG_DIRBASE: dir_frame_r <= cfg_ch.data[19:0];
        default: ;
      endcase
    end
  end

  xsc_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .command(in_ch.command),
    .access_kind(in_ch.access_kind), .offset(in_ch.offset), .seg_base(in_ch.seg_base),
    .seg_limit_raw(in_ch.seg_limit_raw), .descriptor_flags(in_ch.descriptor_flags),
    .selector_rpl(in_ch.selector_rpl), .is_stack_segment(in_ch.is_stack_segment),
    .current_privilege(in_ch.current_privilege), .read_data(in_ch.read_data),
    .paging_enable(paging_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  xsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_cmd(fq_cmd),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_cmd(bq_cmd)
  );

  xsc_back u_back (
    .clk, .rst_n,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_cmd(bq_cmd),
    .page_dir_frame(dir_frame_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.result_kind = res.result_kind;
  assign out_ch.mem_address = res.mem_address;
  assign out_ch.physical_address = res.physical_address;
  assign out_ch.fault_code = res.fault_code;
  assign out_ch.pf_error_bits = res.pf_error_bits;
  assign out_ch.fault_linear_address = res.fault_linear_address;
endmodule

### rtl/xsc_front.sv
// front: segment type, limit and privilege checks, linear address
// depends on xsc_pkg
`timescale 1ns / 1ps
module xsc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [1:0]           access_kind,
  input  logic [31:0]          offset,
  input  logic [31:0]          seg_base,
  input  logic [19:0]          seg_limit_raw,
  input  logic [15:0]          descriptor_flags,
  input  logic [1:0]           selector_rpl,
  input  logic                 is_stack_segment,
  input  logic [1:0]           current_privilege,
  input  logic [31:0]          read_data,
  input  logic                 paging_enable,
  output logic                 q_valid,
  input  logic                 q_ready,
  output xsc_pkg::xsc_cmd_t    q_cmd
);
  logic        cd, exe, b2, rw, big, gran;
  logic [1:0]  dpl, kind;
  logic [31:0] lim, upper;
  logic        type_bad, lim_bad, priv_bad;
  xsc_pkg::xsc_cmd_t cmd_nxt, cmd_r;
  logic        valid_r;

  // decode descriptor and run the three checks
  always_comb begin
    cd   = descriptor_flags[4];
    exe  = descriptor_flags[3];
    b2   = descriptor_flags[2];
    rw   = descriptor_flags[1];
    big  = descriptor_flags[14];
    gran = descriptor_flags[15];
    dpl  = descriptor_flags[6:5];
    kind = (access_kind == 2'd3) ? xsc_pkg::AK_READ : access_kind;
    if (exe) begin
      type_bad = cd && (kind == xsc_pkg::AK_WRITE || (kind == xsc_pkg::AK_READ && !rw));
    end else begin
      type_bad = cd && ((kind == xsc_pkg::AK_WRITE && !rw) || kind == xsc_pkg::AK_EXEC);
    end
    lim   = gran ? {seg_limit_raw, 12'hfff} : {12'd0, seg_limit_raw};
    upper = big ? 32'hffffffff : 32'h0000ffff;
    if (kind != xsc_pkg::AK_EXEC && b2) begin
      lim_bad = (offset <= lim) || (offset > upper);
    end else begin
      lim_bad = offset > lim;
    end
    priv_bad = cd && !(exe && b2) && (dpl < current_privilege || dpl < selector_rpl);
    cmd_nxt.is_resp   = command == xsc_pkg::CMD_RESP;
    cmd_nxt.seg_fault = type_bad || lim_bad || priv_bad;
    cmd_nxt.fcode     = (!type_bad && lim_bad && is_stack_segment) ? xsc_pkg::FC_SS
                                                                   : xsc_pkg::FC_GP;
    cmd_nxt.paging    = paging_enable;
    cmd_nxt.kind      = kind;
    cmd_nxt.cpl       = current_privilege;
    cmd_nxt.linear    = seg_base + offset;
    cmd_nxt.data      = read_data;
  end

  // single output stage register
  assign in_ready = !valid_r || q_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= cmd_nxt;
    end
  end
  assign q_valid = valid_r;
  assign q_cmd   = cmd_r;
endmodule

### rtl/xsc_queue.sv
// short fifo between front and back
// depends on xsc_pkg
`timescale 1ns / 1ps
module xsc_queue #(
  parameter int unsigned DEPTH = xsc_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  xsc_pkg::xsc_cmd_t wr_cmd,
  output logic              rd_valid,
  input  logic              rd_ready,
  output xsc_pkg::xsc_cmd_t rd_cmd
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  xsc_pkg::xsc_cmd_t   mem_r [DEPTH];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;
  logic                push, pop;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_cmd = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_cmd;
  end
endmodule

### rtl/xsc_back.sv
// back: walk state machine and result register
// depends on xsc_pkg
`timescale 1ns / 1ps
module xsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  xsc_pkg::xsc_cmd_t q_cmd,
  input  logic [19:0]       page_dir_frame,
  output logic              res_valid,
  input  logic              res_ready,
  output xsc_pkg::xsc_res_t res
);
  xsc_pkg::walk_phase_t ph_r, ph_nxt;
  logic [31:0] lin_r, lin_nxt, dir_r;
  logic [1:0]  kind_r, kind_nxt, cpl_r, cpl_nxt;
  logic        rv_r, rv_nxt, take, user, wr;
  logic [2:0]  ebase;
  logic [31:0] both;
  xsc_pkg::xsc_res_t res_r, res_nxt;

  assign q_ready = !rv_r || res_ready;
  assign take = q_valid && q_ready;
  assign user = cpl_r == 2'd3;
  assign wr   = kind_r == xsc_pkg::AK_WRITE;
  assign ebase = {user, wr, 1'b0};
  assign both = dir_r & q_cmd.data;

  // next walk state
  always_comb begin
    ph_nxt = ph_r;
    lin_nxt = lin_r;
    kind_nxt = kind_r;
    cpl_nxt = cpl_r;
    if (take) begin
      if (!q_cmd.is_resp) begin
        ph_nxt = xsc_pkg::PH_IDLE;
        if (!q_cmd.seg_fault) begin
          lin_nxt = q_cmd.linear;
          if (q_cmd.paging) begin
            ph_nxt = xsc_pkg::PH_DIR;
            kind_nxt = q_cmd.kind;
            cpl_nxt = q_cmd.cpl;
          end
        end
      end else begin
        case (ph_r)
          xsc_pkg::PH_DIR: ph_nxt = q_cmd.data[0] ? xsc_pkg::PH_TBL : xsc_pkg::PH_IDLE;
          xsc_pkg::PH_TBL: ph_nxt = xsc_pkg::PH_IDLE;
          default:         ph_nxt = ph_r;
        endcase
      end
    end
  end

  // result for the item taken
  always_comb begin
    res_nxt = '0;
    rv_nxt = rv_r && !res_ready;
    if (take) begin
      rv_nxt = 1'b1;
      if (!q_cmd.is_resp) begin
        if (q_cmd.seg_fault) begin
          res_nxt.result_kind = xsc_pkg::RK_FAULT;
          res_nxt.fault_code  = q_cmd.fcode;
        end else if (!q_cmd.paging) begin
          res_nxt.result_kind = xsc_pkg::RK_DONE;
          res_nxt.physical_address = q_cmd.linear;
        end else begin
          res_nxt.result_kind = xsc_pkg::RK_READ;
          res_nxt.mem_address = {page_dir_frame, 12'd0} + {20'd0, q_cmd.linear[31:22], 2'b00};
        end
      end else begin
        case (ph_r)
          xsc_pkg::PH_DIR: begin
            if (!q_cmd.data[0]) begin
              res_nxt.result_kind = xsc_pkg::RK_FAULT;
              res_nxt.fault_code = xsc_pkg::FC_PF;
              res_nxt.pf_error_bits = ebase;
              res_nxt.fault_linear_address = lin_r;
            end else begin
              res_nxt.result_kind = xsc_pkg::RK_READ;
              res_nxt.mem_address = {q_cmd.data[31:12], 12'd0} +
                                    {20'd0, lin_r[21:12], 2'b00};
            end
          end
          xsc_pkg::PH_TBL: begin
            if (!q_cmd.data[0] || (user && !both[2]) || (user && wr && !both[1])) begin
              res_nxt.result_kind = xsc_pkg::RK_FAULT;
              res_nxt.fault_code = xsc_pkg::FC_PF;
              res_nxt.pf_error_bits = ebase | {2'b00, q_cmd.data[0]};
              res_nxt.fault_linear_address = lin_r;
            end else begin
              res_nxt.result_kind = xsc_pkg::RK_DONE;
              res_nxt.physical_address = {q_cmd.data[31:12], lin_r[11:0]};
            end
          end
          default: rv_nxt = rv_r && !res_ready;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= xsc_pkg::PH_IDLE;
      lin_r <= '0;
      kind_r <= '0;
      cpl_r <= '0;
      rv_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      lin_r <= lin_nxt;
      kind_r <= kind_nxt;
      cpl_r <= cpl_nxt;
      rv_r <= rv_nxt;
    end
  end
  // payload registers
  always_ff @(posedge clk) begin
    if (take && q_cmd.is_resp && ph_r == xsc_pkg::PH_DIR) dir_r <= q_cmd.data;
    if (take) res_r <= res_nxt;
  end
  assign res_valid = rv_r;
  assign res = res_r;
endmodule

### rtl/xsc_checker.sv
// port-level checker for the translation block, bound to the top level
// depends on the defines header, xsc_pkg and the interfaces
`timescale 1ns / 1ps
`include "x86_segment_check_page_walk_defines.svh"
module xsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [1:0]  fault_code,
  input logic [2:0]  pf_error_bits,
  input logic [31:0] mem_address,
  input logic [31:0] fault_linear_address
);
  `XSC_ASSERT(a_kind_legal, clk, rst_n,
              out_valid |-> (result_kind == xsc_pkg::RK_READ ||
                result_kind == xsc_pkg::RK_DONE || result_kind == xsc_pkg::RK_FAULT),
              "bad result kind")
  `XSC_ASSERT(a_ecode_pf, clk, rst_n,
              (out_valid && fault_code != xsc_pkg::FC_PF) |->
                pf_error_bits == 3'd0 && fault_linear_address == 32'd0,
              "page fault bits outside page fault")
  `XSC_ASSERT(a_read_aligned, clk, rst_n,
              (out_valid && result_kind == xsc_pkg::RK_READ) |-> mem_address[1:0] == 2'b00,
              "unaligned entry read")
  `XSC_ASSERT(a_hold, clk, rst_n,
              (out_valid && !out_ready) |=> out_valid && $stable(result_kind),
              "result dropped")
endmodule

bind x86_segment_check_page_walk xsc_checker u_xsc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_kind(out_ch.result_kind), .fault_code(out_ch.fault_code),
  .pf_error_bits(out_ch.pf_error_bits), .mem_address(out_ch.mem_address),
  .fault_linear_address(out_ch.fault_linear_address)
);

### tb/tb_x86_segment_check_page_walk.sv
// testbench for the segment check and page walk block: directed table, then random walks
// checks every result against the directed table or an in-bench translation predictor
// depends on xsc_pkg, xsc_if and the block itself
`timescale 1ns / 1ps
module tb_x86_segment_check_page_walk;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomItems = 1600;

  // segment descriptor flag patterns
  localparam logic [15:0] FL_DATA_RW  = 16'h0012;
  localparam logic [15:0] FL_DATA_RO  = 16'h0010;
  localparam logic [15:0] FL_DATA_DN  = 16'h0016;
  localparam logic [15:0] FL_CODE_XO  = 16'h0018;
  localparam logic [15:0] FL_CODE_RX  = 16'h001a;
  localparam logic [15:0] FL_CODE_CF  = 16'h001e;
  localparam logic [15:0] FL_SYSTEM   = 16'h0002;
  localparam logic [15:0] FL_GRAN     = 16'h8000;
  localparam logic [15:0] FL_BIG      = 16'h4000;
  localparam logic [15:0] FL_DPL3     = 16'h0060;

  typedef struct {
    logic        command;
    logic [1:0]  access_kind;
    logic [31:0] offset;
    logic [31:0] seg_base;
    logic [19:0] seg_limit_raw;
    logic [15:0] descriptor_flags;
    logic [1:0]  selector_rpl;
    logic        is_stack_segment;
    logic [1:0]  current_privilege;
    logic [31:0] read_data;
  } xlat_item_t;

  typedef struct {
    bit                is_cfg;
    logic [0:0]        reg_idx;
    logic [31:0]       reg_val;
    xlat_item_t        item;
    bit                typed;
    bit                has_res;
    xsc_pkg::xsc_res_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  xsc_in_if  in_ch();
  xsc_out_if out_ch();
  xsc_cfg_if cfg_ch();

  x86_segment_check_page_walk i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor state
  bit                   paging_on;
  logic [19:0]          dir_frame;
  xsc_pkg::walk_phase_t phase;
  logic [31:0]          pend_lin;
  logic [1:0]           pend_kind;
  logic [1:0]           pend_cpl;
  logic [31:0]          dir_entry;

  xsc_pkg::xsc_res_t expected_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;
  bit          hold_start;
  int unsigned hold_cnt;
  dir_row_t    rows[$];

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic xsc_pkg::xsc_res_t mk_res(logic [1:0] kind, logic [31:0] mem,
                                               logic [31:0] phys, logic [1:0] fc,
                                               logic [2:0] ec, logic [31:0] fla);
    xsc_pkg::xsc_res_t r;
    r.result_kind = kind;
    r.mem_address = mem;
    r.physical_address = phys;
    r.fault_code = fc;
    r.pf_error_bits = ec;
    r.fault_linear_address = fla;
    return r;
  endfunction

  // type, limit and privilege checks; -1 when the segment allows the access
  function automatic int seg_fault_code(xlat_item_t it, logic [1:0] kind);
    logic [15:0] fl;
    logic [31:0] lim;
    logic [31:0] upper;
    logic [1:0]  dpl;
    bit          bad;
    fl = it.descriptor_flags;
    dpl = fl[6:5];
    if (fl[4]) begin
      if (fl[3]) begin
        if (kind == xsc_pkg::AK_WRITE || (kind == xsc_pkg::AK_READ && !fl[1]))
          return int'(xsc_pkg::FC_GP);
      end else begin
        if ((kind == xsc_pkg::AK_WRITE && !fl[1]) || kind == xsc_pkg::AK_EXEC)
          return int'(xsc_pkg::FC_GP);
      end
    end
    lim = {12'h0, it.seg_limit_raw};
    if (fl[15]) lim = {it.seg_limit_raw, 12'hfff};
    if (kind != xsc_pkg::AK_EXEC && fl[2]) begin
      upper = fl[14] ? 32'hffffffff : 32'h0000ffff;
      bad = (it.offset <= lim) || (it.offset > upper);
    end else begin
      bad = it.offset > lim;
    end
    if (bad) return it.is_stack_segment ? int'(xsc_pkg::FC_SS) : int'(xsc_pkg::FC_GP);
    if (fl[4] && !(fl[3] && fl[2])) begin
      if (dpl < it.current_privilege || dpl < it.selector_rpl) return int'(xsc_pkg::FC_GP);
    end
    return -1;
  endfunction

  // translation predictor: returns 1 when the item gives a result
  function automatic bit translate_step(xlat_item_t it, output xsc_pkg::xsc_res_t r);
    logic [1:0]  kind;
    logic [2:0]  ebase;
    logic [31:0] both;
    int          f;
    r = mk_res(xsc_pkg::RK_READ, '0, '0, '0, '0, '0);
    if (it.command == xsc_pkg::CMD_REQ) begin
      kind = (it.access_kind == 2'd3) ? xsc_pkg::AK_READ : it.access_kind;
      phase = xsc_pkg::PH_IDLE;
      f = seg_fault_code(it, kind);
      if (f >= 0) begin
        r = mk_res(xsc_pkg::RK_FAULT, '0, '0, f[1:0], '0, '0);
        return 1;
      end
      pend_lin = it.seg_base + it.offset;
      if (!paging_on) begin
        r = mk_res(xsc_pkg::RK_DONE, '0, pend_lin, '0, '0, '0);
        return 1;
      end
      pend_kind = kind;
      pend_cpl = it.current_privilege;
      phase = xsc_pkg::PH_DIR;
      r = mk_res(xsc_pkg::RK_READ, {dir_frame, 12'h0} + {20'h0, pend_lin[31:22], 2'b00},
                 '0, '0, '0, '0);
      return 1;
    end
    ebase = {pend_cpl == 2'd3, pend_kind == xsc_pkg::AK_WRITE, 1'b0};
    if (phase == xsc_pkg::PH_DIR) begin
      dir_entry = it.read_data;
      if (!it.read_data[0]) begin
        phase = xsc_pkg::PH_IDLE;
        r = mk_res(xsc_pkg::RK_FAULT, '0, '0, xsc_pkg::FC_PF, ebase, pend_lin);
        return 1;
      end
      phase = xsc_pkg::PH_TBL;
      r = mk_res(xsc_pkg::RK_READ,
                 {it.read_data[31:12], 12'h0} + {20'h0, pend_lin[21:12], 2'b00},
                 '0, '0, '0, '0);
      return 1;
    end
    if (phase == xsc_pkg::PH_TBL) begin
      both = dir_entry & it.read_data;
      phase = xsc_pkg::PH_IDLE;
      if (!it.read_data[0])
        r = mk_res(xsc_pkg::RK_FAULT, '0, '0, xsc_pkg::FC_PF, ebase, pend_lin);
      else if (ebase[2] && !both[2])
        r = mk_res(xsc_pkg::RK_FAULT, '0, '0, xsc_pkg::FC_PF, ebase | 3'd1, pend_lin);
      else if (ebase[2] && ebase[1] && !both[1])
        r = mk_res(xsc_pkg::RK_FAULT, '0, '0, xsc_pkg::FC_PF, ebase | 3'd1, pend_lin);
      else
        r = mk_res(xsc_pkg::RK_DONE, '0, {it.read_data[31:12], pend_lin[11:0]},
                   '0, '0, '0);
      return 1;
    end
    return 0;
  endfunction

  function automatic xlat_item_t mk_req(logic [1:0] kind, logic [31:0] off, logic [31:0] base,
                                        logic [19:0] lim, logic [15:0] fl, logic [1:0] rpl,
                                        logic stk, logic [1:0] cpl);
    xlat_item_t it;
    it.command = xsc_pkg::CMD_REQ;
    it.access_kind = kind;
    it.offset = off;
    it.seg_base = base;
    it.seg_limit_raw = lim;
    it.descriptor_flags = fl;
    it.selector_rpl = rpl;
    it.is_stack_segment = stk;
    it.current_privilege = cpl;
    it.read_data = $urandom;
    return it;
  endfunction

  function automatic xlat_item_t mk_resp(logic [31:0] data);
    xlat_item_t it;
    it = mk_req(2'($urandom_range(3)), $urandom, $urandom, 20'($urandom), 16'($urandom),
                2'($urandom_range(3)), 1'($urandom_range(1)), 2'($urandom_range(3)));
    it.command = xsc_pkg::CMD_RESP;
    it.read_data = data;
    return it;
  endfunction

  function automatic void add_item(xlat_item_t it, bit typed = 0, bit has = 0,
                                   xsc_pkg::xsc_res_t r = '0);
    dir_row_t row;
    row.is_cfg = 0;
    row.item = it;
    row.typed = typed;
    row.has_res = has;
    row.res = r;
    rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [0:0] idx, logic [31:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1;
    row.reg_idx = idx;
    row.reg_val = val;
    rows.push_back(row);
  endfunction

  // well-formed request with random content, or full noise
  function automatic xlat_item_t rand_req(bit clean);
    logic [15:0] fl;
    logic [19:0] lim;
    logic [1:0]  kind;
    logic [31:0] off;
    if (!clean)
      return mk_req(2'($urandom_range(3)), $urandom, $urandom, 20'($urandom), 16'($urandom),
                    2'($urandom_range(3)), 1'($urandom_range(1)), 2'($urandom_range(3)));
    case ($urandom_range(5))
      0: begin fl = FL_DATA_RW; kind = 2'($urandom_range(1)); end
      1: begin fl = FL_DATA_RO; kind = xsc_pkg::AK_READ; end
      2: begin
        fl = FL_CODE_RX;
        kind = $urandom_range(1) ? xsc_pkg::AK_EXEC : xsc_pkg::AK_READ;
      end
      3: begin fl = FL_CODE_CF; kind = xsc_pkg::AK_EXEC; end
      4: begin fl = FL_SYSTEM; kind = 2'($urandom_range(2)); end
      default: begin fl = FL_DATA_DN; kind = 2'($urandom_range(1)); end
    endcase
    if ($urandom_range(3) != 0) fl |= FL_DPL3;
    if ($urandom_range(1)) fl |= FL_GRAN;
    if ($urandom_range(1)) fl |= FL_BIG;
    lim = 20'($urandom);
    off = $urandom;
    if (fl == (fl & ~FL_DATA_DN | FL_DATA_DN) && fl[3] == 1'b0 && fl[2]) begin
      if ($urandom_range(3) != 0) off = fl[15] ? {lim, 12'hfff} + 1 + ($urandom & 32'hfff)
                                                : {12'h0, lim} + 1 + ($urandom & 32'hff);
    end else if ($urandom_range(3) != 0) begin
      off = fl[15] ? ($urandom % ({12'h0, lim} + 1)) << 12 : $urandom % ({12'h0, lim} + 1);
    end
    return mk_req(kind, off, $urandom, lim, fl, 2'($urandom_range(3)),
                  1'($urandom_range(1)), 2'($urandom_range(3)));
  endfunction

  function automatic logic [31:0] rand_entry();
    logic [31:0] d;
    d = $urandom;
    if ($urandom_range(9) != 0) d[0] = 1'b1;
    if ($urandom_range(9) < 7) d[2:1] = 2'b11;
    return d;
  endfunction

  // result checking
  always @(posedge clk) begin
    xsc_pkg::xsc_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_ch.result_kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.result_kind !== e.result_kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, e.result_kind,
                   out_ch.result_kind);
          errors++;
        end
        if (out_ch.mem_address !== e.mem_address) begin
          $display("%0t: mem_address expected %h actual %h", $time, e.mem_address,
                   out_ch.mem_address);
          errors++;
        end
        if (out_ch.physical_address !== e.physical_address) begin
          $display("%0t: physical_address expected %h actual %h", $time,
                   e.physical_address, out_ch.physical_address);
          errors++;
        end
        if (out_ch.fault_code !== e.fault_code) begin
          $display("%0t: fault_code expected %0d actual %0d", $time, e.fault_code,
                   out_ch.fault_code);
          errors++;
        end
        if (out_ch.pf_error_bits !== e.pf_error_bits) begin
          $display("%0t: pf_error_bits expected %0d actual %0d", $time, e.pf_error_bits,
                   out_ch.pf_error_bits);
          errors++;
        end
        if (out_ch.fault_linear_address !== e.fault_linear_address) begin
          $display("%0t: fault_linear_address expected %h actual %h", $time,
                   e.fault_linear_address, out_ch.fault_linear_address);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with one long hold counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_start) begin
        hold_cnt = 80;
        hold_start = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // send one item and update the prediction when it is taken
  task automatic send_item(xlat_item_t it, bit typed = 0, bit has = 0,
                           xsc_pkg::xsc_res_t tr = '0);
    xsc_pkg::xsc_res_t r;
    bit                gives;
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.access_kind <= it.access_kind;
    in_ch.offset <= it.offset;
    in_ch.seg_base <= it.seg_base;
    in_ch.seg_limit_raw <= it.seg_limit_raw;
    in_ch.descriptor_flags <= it.descriptor_flags;
    in_ch.selector_rpl <= it.selector_rpl;
    in_ch.is_stack_segment <= it.is_stack_segment;
    in_ch.current_privilege <= it.current_privilege;
    in_ch.read_data <= it.read_data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gives = translate_step(it, r);
    if (typed) begin
      if (has) expected_q.push_back(tr);
    end else if (gives) begin
      expected_q.push_back(r);
    end
    if (!quiet && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // register write, only from an idle block
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == xsc_pkg::REG_PAGING) paging_on = val[0];
    else dir_frame = val[19:0];
  endtask

  // stimulus
  initial begin
    xlat_item_t it;
    int unsigned n;
    int unsigned nresp;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= xsc_pkg::CMD_REQ;
    in_ch.access_kind <= xsc_pkg::AK_READ;
    in_ch.offset <= '0;
    in_ch.seg_base <= '0;
    in_ch.seg_limit_raw <= '0;
    in_ch.descriptor_flags <= '0;
    in_ch.selector_rpl <= '0;
    in_ch.is_stack_segment <= 1'b0;
    in_ch.current_privilege <= '0;
    in_ch.read_data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= xsc_pkg::REG_PAGING;
    cfg_ch.data <= '0;
    paging_on = 0;
    dir_frame = '0;
    phase = xsc_pkg::PH_IDLE;
    pend_lin = '0;
    pend_kind = '0;
    pend_cpl = '0;
    dir_entry = '0;
    errors = 0;
    cycles = 0;
    quiet = 0;
    hold_start = 0;
    hold_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: segment checks with paging off after reset
    add_item(mk_req(xsc_pkg::AK_READ, 32'hffffffff, 0, 20'hfffff, FL_DATA_RW | FL_GRAN,
                    0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 32'hffffffff, 0, 0, 0));
    add_item(mk_req(xsc_pkg::AK_WRITE, 0, 0, 20'hfffff, FL_CODE_RX, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_EXEC, 0, 0, 20'hfffff, FL_DATA_RW, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 0, 0, 20'hfffff, FL_CODE_XO, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 1, 0, 0, FL_DATA_RW, 0, 1, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_SS, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 1, 0, 0, FL_DATA_RW, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_WRITE, 32'h100, 32'h1000, 20'h000ff, FL_DATA_DN, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 32'h1100, 0, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 32'h10000, 0, 20'h000ff, FL_DATA_DN, 0, 1, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_SS, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 32'hffffffff, 1, 0, FL_DATA_DN | FL_BIG, 0, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 0, 0, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 5, 0, 20'hfffff, FL_DATA_RW, 0, 0, 3),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_READ, 5, 0, 20'hfffff, FL_DATA_RW, 3, 0, 0),
             1, 1, mk_res(xsc_pkg::RK_FAULT, 0, 0, xsc_pkg::FC_GP, 0, 0));
    add_item(mk_req(xsc_pkg::AK_EXEC, 5, 32'hfffffff0, 20'hfffff, FL_CODE_CF, 3, 0, 3),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 32'hfffffff5, 0, 0, 0));
    add_item(mk_req(xsc_pkg::AK_WRITE, 7, 0, 20'hfffff, FL_SYSTEM, 3, 0, 3),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 7, 0, 0, 0));
    add_item(mk_req(2'd3, 9, 0, 20'hfffff, FL_DATA_RW | FL_DPL3, 3, 0, 3),
             1, 1, mk_res(xsc_pkg::RK_DONE, 0, 9, 0, 0, 0));
    add_item(mk_resp(32'hffffffff), 1, 0);
    // directed: page walks
    add_cfg(xsc_pkg::REG_PAGING, 1);
    add_cfg(xsc_pkg::REG_DIRBASE, 32'hfffff);
    add_item(mk_req(xsc_pkg::AK_READ, 32'hffffffff, 0, 20'hfffff,
                    FL_DATA_RW | FL_GRAN | FL_DPL3, 3, 0, 3),
             1, 1, mk_res(xsc_pkg::RK_READ, 32'hfffffffc, 0, 0, 0, 0));
    add_item(mk_resp(32'hffffffff));
    add_item(mk_resp(32'hffffffff));
    add_item(mk_req(xsc_pkg::AK_WRITE, 32'h12345678, 0, 20'hfffff,
                    FL_DATA_RW | FL_GRAN | FL_DPL3, 3, 0, 3));
    add_item(mk_resp(32'h00000001));
    add_item(mk_resp(32'hfffff007));
    add_item(mk_req(xsc_pkg::AK_WRITE, 32'h00400000, 0, 20'hfffff, FL_DATA_RW | FL_GRAN,
                    0, 0, 3));
    add_item(mk_resp(32'h00000000));
    add_item(mk_req(xsc_pkg::AK_READ, 32'h00401000, 0, 20'hfffff, FL_DATA_RW | FL_GRAN,
                    0, 0, 0));
    add_item(mk_resp(32'h00000003));
    add_item(mk_req(xsc_pkg::AK_READ, 32'h00801000, 0, 20'hfffff, FL_DATA_RW | FL_GRAN,
                    0, 0, 0));
    add_item(mk_resp(32'hfffff005));
    add_cfg(xsc_pkg::REG_DIRBASE, 0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_item(rows[i].item, rows[i].typed, rows[i].has_res, rows[i].res);
    end

    // random walks with occasional noise and register changes
    n = 0;
    while (n < RandomItems) begin
      if (n % 300 == 0) begin
        case ($urandom_range(3))
          0: write_reg(xsc_pkg::REG_DIRBASE, 0);
          1: write_reg(xsc_pkg::REG_DIRBASE, 32'hfffff);
          default: write_reg(xsc_pkg::REG_DIRBASE, $urandom);
        endcase
        write_reg(xsc_pkg::REG_PAGING, {31'd0, (n / 300) % 4 != 1});
      end
      if (n == 400) hold_start = 1;
      if (n == 800) drain();
      quiet = (n >= 1000 && n < 1300);
      if ($urandom_range(9) < 8) begin
        send_item(rand_req(1));
        n++;
        nresp = $urandom_range(9) < 8 ? 2 : $urandom_range(1);
        repeat (nresp) begin
          send_item(mk_resp(rand_entry()));
          n++;
        end
      end else begin
        it = $urandom_range(1) ? rand_req(0) : mk_resp($urandom);
        send_item(it);
        n++;
      end
    end
    quiet = 0;

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/xsc_pkg.sv
rtl/xsc_if.sv
rtl/xsc_front.sv
rtl/xsc_queue.sv
rtl/xsc_back.sv
rtl/x86_segment_check_page_walk.sv
rtl/xsc_checker.sv
tb/tb_x86_segment_check_page_walk.sv
